### rtl/core/three_axis_bresenham_stepper_unit_defines.svh
// ----------------------------------------------------------------------------
// three_axis_bresenham_stepper_unit_defines
// assertion macros shared by the stepper rtl, clocked on aclk and
// disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_BRESENHAM_STEPPER_UNIT_DEFINES_SVH
`define THREE_AXIS_BRESENHAM_STEPPER_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define TABS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define TABS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tabs_pkg.sv
// ----------------------------------------------------------------------------
// tabs_pkg
// shared types, widths and coil tables of the three axis line stepper
// ----------------------------------------------------------------------------
package tabs_pkg;

    localparam int FIELD_BITS     = 32;
    localparam int POS_BITS_DEF   = 32;
    localparam int ERR_BITS       = 34;
    localparam int PHASE_BITS     = 4;
    localparam int PHASE_IDX_BITS = 3;
    localparam int PHASE_COUNT    = 8;
    localparam int REP_BITS       = 4;
    localparam int COIL_BITS      = 5;
    localparam int AXES           = 3;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 4;
    localparam int REG_IDX_BITS   = 2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // two bit signed step direction
    typedef enum logic [1:0] {
        DIR_NONE = 2'b00,
        DIR_POS  = 2'b01,
        DIR_NEG  = 2'b11
    } dir_t;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_STEP_REPEAT_X = 2'd0,
        REG_STEP_REPEAT_Y = 2'd1,
        REG_STEP_REPEAT_Z = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic load;
        logic tick;
        logic all_zero;
        logic is_major;
    } axis_ctrl_t;

    typedef struct packed {
        logic count_zero;
        logic at_target;
        logic at_target_next;
    } axis_stat_t;

    localparam logic [COIL_BITS-1:0] COIL_X [8] =
        '{5'h10, 5'h18, 5'h08, 5'h0C, 5'h04, 5'h06, 5'h02, 5'h12};
    localparam logic [COIL_BITS-1:0] COIL_Y [8] =
        '{5'h10, 5'h14, 5'h04, 5'h0C, 5'h08, 5'h09, 5'h01, 5'h11};
    localparam logic [COIL_BITS-1:0] COIL_Z [8] =
        '{5'h02, 5'h0A, 5'h08, 5'h09, 5'h01, 5'h05, 5'h04, 5'h06};

    function automatic logic [COIL_BITS-1:0] coil_lookup(
        axis_t                     axis,
        logic [PHASE_IDX_BITS-1:0] idx
    );
        logic [COIL_BITS-1:0] pat;
        case (axis)
            AXIS_X:  pat = COIL_X[idx];
            AXIS_Y:  pat = COIL_Y[idx];
            AXIS_Z:  pat = COIL_Z[idx];
            default: pat = COIL_X[idx];
        endcase
        return pat;
    endfunction

endpackage

### rtl/core/tabs_axis.sv
// ----------------------------------------------------------------------------
// tabs_axis
// per axis state and next state: load setup, chained phase steps,
// bresenham error update and coil pattern
// ----------------------------------------------------------------------------
`include "three_axis_bresenham_stepper_unit_defines.svh"

module tabs_axis #(
    parameter int              POS_BITS = tabs_pkg::POS_BITS_DEF,
    parameter tabs_pkg::axis_t AXIS     = tabs_pkg::AXIS_X
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tabs_pkg::axis_ctrl_t            ctrl,
    input  logic [tabs_pkg::REP_BITS-1:0]   step_repeat,
    input  logic [tabs_pkg::FIELD_BITS-1:0] target,
    input  logic [POS_BITS-1:0]             major_delta,
    output tabs_pkg::axis_stat_t            stat,
    output logic [POS_BITS-1:0]             delta_load,
    output logic [POS_BITS-1:0]             delta,
    output logic [tabs_pkg::COIL_BITS-1:0]  coil_next,
    output logic [tabs_pkg::FIELD_BITS-1:0] position_next
);

    typedef struct packed {
        logic [POS_BITS-1:0]              pos;
        logic [tabs_pkg::PHASE_BITS-1:0]  phase;
        logic [tabs_pkg::REP_BITS-1:0]    count;
        logic [tabs_pkg::COIL_BITS-1:0]   coil;
    } step_t;

    logic [POS_BITS-1:0]             pos_reg;
    logic [POS_BITS-1:0]             target_reg;
    logic [POS_BITS-1:0]             delta_reg;
    tabs_pkg::dir_t                  dir_reg;
    logic [tabs_pkg::ERR_BITS-1:0]   err_reg;
    logic [tabs_pkg::PHASE_BITS-1:0] phase_reg;
    logic [tabs_pkg::REP_BITS-1:0]   count_reg;
    logic [tabs_pkg::COIL_BITS-1:0]  coil_reg;

    step_t                           cur;
    step_t                           s1;
    step_t                           s2;
    step_t                           reload;
    logic                            at1;
    logic [tabs_pkg::REP_BITS-1:0]   rep;
    logic [tabs_pkg::ERR_BITS-1:0]   err_add;
    logic                            err_hit;
    logic [tabs_pkg::ERR_BITS-1:0]   err_next;
    logic [POS_BITS-1:0]             tgt_load;
    logic [POS_BITS:0]               diff;
    logic [POS_BITS:0]               diff_neg;
    tabs_pkg::dir_t                  dir_load;
    logic [POS_BITS-1:0]             pos_sel;

    function automatic step_t phase_step(step_t st, tabs_pkg::dir_t dir);
        step_t                           nxt;
        logic [tabs_pkg::PHASE_BITS-1:0] ph;
        logic [1:0]                      dir_bits;
        nxt      = st;
        ph       = st.phase;
        dir_bits = dir;
        // phase wraps into 1..PHASE_COUNT before use
        if (ph == '0) begin
            ph = tabs_pkg::PHASE_BITS'(tabs_pkg::PHASE_COUNT);
        end else if (ph > tabs_pkg::PHASE_BITS'(tabs_pkg::PHASE_COUNT)) begin
            ph = tabs_pkg::PHASE_BITS'(1);
        end
        nxt.coil = tabs_pkg::coil_lookup(AXIS,
                       tabs_pkg::PHASE_IDX_BITS'(ph - tabs_pkg::PHASE_BITS'(1)));
        case (dir)
            tabs_pkg::DIR_POS: nxt.phase = ph + tabs_pkg::PHASE_BITS'(1);
            tabs_pkg::DIR_NEG: nxt.phase = ph - tabs_pkg::PHASE_BITS'(1);
            default:           nxt.phase = ph;
        endcase
        nxt.count = st.count - tabs_pkg::REP_BITS'(1);
        if (nxt.count == '0) begin
            nxt.pos = st.pos + {{(POS_BITS-2){dir_bits[1]}}, dir_bits};
        end
        return nxt;
    endfunction

    // tick path
    always_comb begin
        cur      = '{pos: pos_reg, phase: phase_reg, count: count_reg, coil: coil_reg};
        s1       = (count_reg != '0) ? phase_step(cur, dir_reg) : cur;
        at1      = (s1.pos == target_reg);
        rep      = (step_repeat == '0) ? tabs_pkg::REP_BITS'(1) : step_repeat;
        err_add  = err_reg + tabs_pkg::ERR_BITS'(delta_reg);
        // 2*error >= major delta, compared one bit wider
        err_hit  = $signed({err_add, 1'b0}) >=
                   $signed({1'b0, tabs_pkg::ERR_BITS'(major_delta)});
        reload       = s1;
        reload.count = rep;
        s2       = s1;
        err_next = err_reg;
        if (ctrl.all_zero && !at1) begin
            if (ctrl.is_major) begin
                s2 = phase_step(reload, dir_reg);
            end else if (dir_reg != tabs_pkg::DIR_NONE) begin
                err_next = err_add;
                if (err_hit) begin
                    err_next = err_add - tabs_pkg::ERR_BITS'(major_delta);
                    s2       = phase_step(reload, dir_reg);
                end
            end
        end
        stat.count_zero     = (s1.count == '0);
        stat.at_target      = (pos_reg == target_reg);
        stat.at_target_next = (s2.pos == target_reg);
    end

    // load path
    always_comb begin
        tgt_load = target[POS_BITS-1:0];
        diff     = {tgt_load[POS_BITS-1], tgt_load} - {pos_reg[POS_BITS-1], pos_reg};
        diff_neg = -diff;
        if (diff[POS_BITS]) begin
            dir_load   = tabs_pkg::DIR_NEG;
            delta_load = diff_neg[POS_BITS-1:0];
        end else if (diff != '0) begin
            dir_load   = tabs_pkg::DIR_POS;
            delta_load = diff[POS_BITS-1:0];
        end else begin
            dir_load   = tabs_pkg::DIR_NONE;
            delta_load = '0;
        end
    end

    always_comb begin
        pos_sel       = ctrl.tick ? s2.pos : pos_reg;
        position_next = tabs_pkg::FIELD_BITS'($signed(pos_sel));
        coil_next     = ctrl.tick ? s2.coil : coil_reg;
        delta         = delta_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            target_reg <= '0;
            delta_reg  <= '0;
            dir_reg    <= tabs_pkg::DIR_NONE;
            err_reg    <= '0;
            phase_reg  <= '0;
            count_reg  <= '0;
            coil_reg   <= '0;
        end else if (ctrl.load) begin
            target_reg <= tgt_load;
            dir_reg    <= dir_load;
            delta_reg  <= delta_load;
            err_reg    <= '0;
            count_reg  <= '0;
        end else if (ctrl.tick) begin
            pos_reg    <= s2.pos;
            phase_reg  <= s2.phase;
            count_reg  <= s2.count;
            coil_reg   <= s2.coil;
            err_reg    <= err_next;
        end
    end

    `TABS_ASSERT_NOW(a_phase_range, 1'b1, phase_reg <= tabs_pkg::PHASE_BITS'(tabs_pkg::PHASE_COUNT + 1), "phase left its wrap range")
    `TABS_ASSERT_NEXT(a_load_keeps_motion, ctrl.load, $stable(pos_reg) && $stable(coil_reg), "load moved the axis")
    `TABS_ASSERT_NEXT(a_load_clears_count, ctrl.load, count_reg == '0 && err_reg == '0, "load left a pending step")

endmodule

### rtl/core/three_axis_bresenham_stepper_unit.sv
// ----------------------------------------------------------------------------
// three_axis_bresenham_stepper_unit
// three axis bresenham line stepper with half step coil patterns
// ----------------------------------------------------------------------------
// One item per clock: a load or tick is taken whenever the result register is
// empty or being drained, and its result appears in the result register in the
// cycle after acceptance. The cycle is set by the per axis next-state pass, which
// holds up to two chained phase steps and the 34 bit error add and compare.
// Users must write step_repeat registers over apb only while idle; unenforced.
`include "three_axis_bresenham_stepper_unit_defines.svh"

module three_axis_bresenham_stepper_unit #(
    parameter int POS_BITS = tabs_pkg::POS_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input item channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_op,
    input  logic [tabs_pkg::FIELD_BITS-1:0]    s_target_x,
    input  logic [tabs_pkg::FIELD_BITS-1:0]    s_target_y,
    input  logic [tabs_pkg::FIELD_BITS-1:0]    s_target_z,
    input  logic                               s_running,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tabs_pkg::COIL_BITS-1:0]     m_coil_x,
    output logic [tabs_pkg::COIL_BITS-1:0]     m_coil_y,
    output logic [tabs_pkg::COIL_BITS-1:0]     m_coil_z,
    output logic [tabs_pkg::FIELD_BITS-1:0]    m_position_x,
    output logic [tabs_pkg::FIELD_BITS-1:0]    m_position_y,
    output logic [tabs_pkg::FIELD_BITS-1:0]    m_position_z,
    output logic                               m_finished,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tabs_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [tabs_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [tabs_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);

    localparam int AXES = tabs_pkg::AXES;

    logic [tabs_pkg::REP_BITS-1:0]     rep_reg [AXES];
    tabs_pkg::axis_t                   major_reg;
    tabs_pkg::axis_t                   major_next;
    logic                              m_valid_reg;
    logic [tabs_pkg::COIL_BITS-1:0]    coil_reg [AXES];
    logic [tabs_pkg::FIELD_BITS-1:0]   pos_reg [AXES];
    logic                              fin_reg;
    logic                              fin_next;

    logic [tabs_pkg::FIELD_BITS-1:0]   tgt_in [AXES];
    tabs_pkg::axis_ctrl_t              ctrl [AXES];
    tabs_pkg::axis_stat_t              stat [AXES];
    logic [POS_BITS-1:0]               delta_load [AXES];
    logic [POS_BITS-1:0]               delta [AXES];
    logic [tabs_pkg::COIL_BITS-1:0]    coil_next [AXES];
    logic [tabs_pkg::FIELD_BITS-1:0]   pos_next [AXES];
    logic [POS_BITS-1:0]               major_delta;
    logic [tabs_pkg::REG_IDX_BITS-1:0] cfg_idx;

    logic                              s_fire;
    logic                              is_load;
    logic                              all_at;
    logic                              all_zero;
    logic                              advance;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign is_load = (s_op == tabs_pkg::OP_LOAD);

    assign tgt_in[0] = s_target_x;
    assign tgt_in[1] = s_target_y;
    assign tgt_in[2] = s_target_z;

    assign all_at   = stat[0].at_target && stat[1].at_target && stat[2].at_target;
    assign all_zero = stat[0].count_zero && stat[1].count_zero && stat[2].count_zero;
    // a tick moves only while running and not yet at every target
    assign advance  = s_fire && !is_load && s_running && !all_at;

    always_comb begin
        case (major_reg)
            tabs_pkg::AXIS_Y: major_delta = delta[1];
            tabs_pkg::AXIS_Z: major_delta = delta[2];
            default:          major_delta = delta[0];
        endcase
    end

    for (genvar i = 0; i < AXES; i++) begin : g_axis
        assign ctrl[i] = '{
            load:     s_fire && is_load,
            tick:     advance,
            all_zero: all_zero,
            is_major: (major_reg == tabs_pkg::axis_t'(i))
        };

        tabs_axis #(
            .POS_BITS (POS_BITS),
            .AXIS     (tabs_pkg::axis_t'(i))
        ) u_axis (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl          (ctrl[i]),
            .step_repeat   (rep_reg[i]),
            .target        (tgt_in[i]),
            .major_delta   (major_delta),
            .stat          (stat[i]),
            .delta_load    (delta_load[i]),
            .delta         (delta[i]),
            .coil_next     (coil_next[i]),
            .position_next (pos_next[i])
        );
    end

    // ties go to x, then y over z
    always_comb begin
        if (delta_load[0] >= delta_load[1] && delta_load[0] >= delta_load[2]) begin
            major_next = tabs_pkg::AXIS_X;
        end else if (delta_load[1] >= delta_load[2]) begin
            major_next = tabs_pkg::AXIS_Y;
        end else begin
            major_next = tabs_pkg::AXIS_Z;
        end
    end

    always_comb begin
        if (is_load) begin
            fin_next = 1'b0;
        end else if (!s_running || all_at) begin
            fin_next = 1'b1;
        end else begin
            fin_next = all_zero && stat[0].at_target_next &&
                       stat[1].at_target_next && stat[2].at_target_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            major_reg <= tabs_pkg::AXIS_X;
        end else if (s_fire && is_load) begin
            major_reg <= major_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int a = 0; a < AXES; a++) begin
                coil_reg[a] <= coil_next[a];
                pos_reg[a]  <= pos_next[a];
            end
            fin_reg <= fin_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_coil_x     = coil_reg[0];
    assign m_coil_y     = coil_reg[1];
    assign m_coil_z     = coil_reg[2];
    assign m_position_x = pos_reg[0];
    assign m_position_y = pos_reg[1];
    assign m_position_z = pos_reg[2];
    assign m_finished   = fin_reg;

    // apb registers
    assign pready  = 1'b1;
    assign cfg_idx = paddr[tabs_pkg::APB_ADDR_BITS-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                rep_reg[a] <= tabs_pkg::REP_BITS'(1);
            end
        end else if (psel && penable && pwrite && pready) begin
            case (cfg_idx)
                tabs_pkg::REG_STEP_REPEAT_X: rep_reg[0] <= pwdata[tabs_pkg::REP_BITS-1:0];
                tabs_pkg::REG_STEP_REPEAT_Y: rep_reg[1] <= pwdata[tabs_pkg::REP_BITS-1:0];
                tabs_pkg::REG_STEP_REPEAT_Z: rep_reg[2] <= pwdata[tabs_pkg::REP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            tabs_pkg::REG_STEP_REPEAT_X: prdata = tabs_pkg::APB_DATA_BITS'(rep_reg[0]);
            tabs_pkg::REG_STEP_REPEAT_Y: prdata = tabs_pkg::APB_DATA_BITS'(rep_reg[1]);
            tabs_pkg::REG_STEP_REPEAT_Z: prdata = tabs_pkg::APB_DATA_BITS'(rep_reg[2]);
            default:                     prdata = '0;
        endcase
    end

    `TABS_ASSERT_NEXT(a_load_not_finished, s_fire && is_load, m_valid && !m_finished, "load item reported finished")
    `TABS_ASSERT_NEXT(a_idle_tick_finished, s_fire && !is_load && (!s_running || all_at), m_valid && m_finished, "idle tick not reported finished")
    `TABS_ASSERT_NOW(a_ready_when_empty, !m_valid_reg, s_ready, "input stalled with empty result register")

endmodule

### tb/three_axis_bresenham_stepper_unit_tb.sv
// ----------------------------------------------------------------------------
// three_axis_bresenham_stepper_unit_tb
// Drives load and tick commands into the line stepper through random idle
// and stall bursts. Coil patterns, positions and the finished flag are
// checked against an in-bench stepper model. The step repeat registers are
// rewritten over apb between phases while the stream is drained.
// ----------------------------------------------------------------------------
module three_axis_bresenham_stepper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;
    localparam int IDLE_PCT [4] = '{0, 5, 20, 50};

    localparam logic [tabs_pkg::COIL_BITS-1:0] HALF_STEP [3][8] = '{
        '{5'h10, 5'h18, 5'h08, 5'h0C, 5'h04, 5'h06, 5'h02, 5'h12},
        '{5'h10, 5'h14, 5'h04, 5'h0C, 5'h08, 5'h09, 5'h01, 5'h11},
        '{5'h02, 5'h0A, 5'h08, 5'h09, 5'h01, 5'h05, 5'h04, 5'h06}
    };

    typedef struct packed {
        tabs_pkg::op_t op;
        logic [31:0]   target_x;
        logic [31:0]   target_y;
        logic [31:0]   target_z;
        logic          running;
    } stepper_cmd_t;

    typedef struct packed {
        logic [4:0]  coil_x;
        logic [4:0]  coil_y;
        logic [4:0]  coil_z;
        logic [31:0] position_x;
        logic [31:0] position_y;
        logic [31:0] position_z;
        logic        finished;
    } step_result_t;

    typedef struct packed {
        logic [2:0][3:0]  repeat_cfg;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] tgt;
        logic [2:0][32:0] span;
        logic [2:0][1:0]  dir;
        logic [2:0][33:0] err;
        logic [2:0][3:0]  phase;
        logic [2:0][3:0]  count;
        logic [2:0][4:0]  coil;
        tabs_pkg::axis_t  major;
    } stepper_state_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = 1'b0;
    logic [31:0] s_target_x = '0;
    logic [31:0] s_target_y = '0;
    logic [31:0] s_target_z = '0;
    logic        s_running = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [4:0]  m_coil_x;
    logic [4:0]  m_coil_y;
    logic [4:0]  m_coil_z;
    logic [31:0] m_position_x;
    logic [31:0] m_position_y;
    logic [31:0] m_position_z;
    logic        m_finished;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [tabs_pkg::APB_ADDR_BITS-1:0] paddr = '0;
    logic [tabs_pkg::APB_DATA_BITS-1:0] pwdata = '0;
    logic [tabs_pkg::APB_DATA_BITS-1:0] prdata;
    logic        pready;

    stepper_cmd_t   cmd_fifo [$];
    step_result_t   coil_pos_fifo [$];
    stepper_state_t plan;
    stepper_state_t live;
    stepper_cmd_t   cmd_on_bus;
    stepper_cmd_t   seen_cmd;
    step_result_t   want_res;
    int cmds_planned = 0;
    int cmds_taken = 0;
    int result_idx = 0;
    int mismatch_count = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;

    three_axis_bresenham_stepper_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_target_x   (s_target_x),
        .s_target_y   (s_target_y),
        .s_target_z   (s_target_z),
        .s_running    (s_running),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_coil_x     (m_coil_x),
        .m_coil_y     (m_coil_y),
        .m_coil_z     (m_coil_z),
        .m_position_x (m_position_x),
        .m_position_y (m_position_y),
        .m_position_z (m_position_z),
        .m_finished   (m_finished),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // stepper model
    // ------------------------------------------------------------------------
    function automatic stepper_state_t home_state();
        stepper_state_t st;
        st = '0;
        st.repeat_cfg = {4'd1, 4'd1, 4'd1};
        st.major = tabs_pkg::AXIS_X;
        return st;
    endfunction

    // a programmed zero behaves as one
    function automatic logic [3:0] repeat_eff(stepper_state_t st, tabs_pkg::axis_t a);
        return (st.repeat_cfg[a] == 4'd0) ? 4'd1 : st.repeat_cfg[a];
    endfunction

    function automatic bit axes_home(stepper_state_t st);
        return st.pos == st.tgt;
    endfunction

    function automatic void advance_phase(inout stepper_state_t st,
                                          input tabs_pkg::axis_t a);
        logic [2:0]  idx;
        logic [31:0] inc;
        if (st.phase[a] < 4'd1 || st.phase[a] > tabs_pkg::PHASE_COUNT) begin
            st.phase[a] = (st.phase[a] < 4'd1) ? 4'(tabs_pkg::PHASE_COUNT) : 4'd1;
        end
        idx = 3'(st.phase[a] - 4'd1);
        st.coil[a] = HALF_STEP[a][idx];
        case (st.dir[a])
            tabs_pkg::DIR_POS: begin
                st.phase[a] = st.phase[a] + 4'd1;
                inc = 32'd1;
            end
            tabs_pkg::DIR_NEG: begin
                st.phase[a] = st.phase[a] - 4'd1;
                inc = '1;
            end
            default: inc = '0;
        endcase
        st.count[a] = st.count[a] - 4'd1;
        if (st.count[a] == 4'd0) begin
            st.pos[a] = st.pos[a] + inc;
        end
    endfunction

    // bresenham error update of a minor axis against the major distance
    function automatic void minor_advance(inout stepper_state_t st,
                                          input tabs_pkg::axis_t a,
                                          input logic [32:0] dmaj);
        logic signed [33:0] e;
        longint twice;
        longint lim;
        if (st.pos[a] == st.tgt[a] || st.dir[a] == tabs_pkg::DIR_NONE) return;
        st.err[a] = st.err[a] + {1'b0, st.span[a]};
        e = st.err[a];
        twice = e;
        twice = twice * 2;
        lim = dmaj;
        if (twice >= lim) begin
            st.err[a] = st.err[a] - {1'b0, dmaj};
            st.count[a] = repeat_eff(st, a);
            advance_phase(st, a);
        end
    endfunction

    function automatic step_result_t stepper_advance(inout stepper_state_t st,
                                                     input stepper_cmd_t cmd);
        step_result_t     res;
        logic [2:0][31:0] tv;
        longint           d;
        logic             fin;
        tabs_pkg::axis_t  m;
        tabs_pkg::axis_t  mb;
        tabs_pkg::axis_t  mc;
        fin = 1'b0;
        if (cmd.op == tabs_pkg::OP_LOAD) begin
            tv = {cmd.target_z, cmd.target_y, cmd.target_x};
            for (int a = 0; a < tabs_pkg::AXES; a++) begin
                d = $signed(tv[a]) - $signed(st.pos[a]);
                st.tgt[a] = tv[a];
                st.dir[a] = (d > 0) ? tabs_pkg::DIR_POS :
                            ((d < 0) ? tabs_pkg::DIR_NEG : tabs_pkg::DIR_NONE);
                st.span[a] = 33'((d < 0) ? -d : d);
                st.err[a] = '0;
                st.count[a] = '0;
            end
            if (st.span[0] >= st.span[1] && st.span[0] >= st.span[2]) begin
                st.major = tabs_pkg::AXIS_X;
            end else if (st.span[1] >= st.span[2]) begin
                st.major = tabs_pkg::AXIS_Y;
            end else begin
                st.major = tabs_pkg::AXIS_Z;
            end
        end else if (!cmd.running || axes_home(st)) begin
            fin = 1'b1;
        end else begin
            m = st.major;
            case (m)
                tabs_pkg::AXIS_Y: begin
                    mb = tabs_pkg::AXIS_X;
                    mc = tabs_pkg::AXIS_Z;
                end
                tabs_pkg::AXIS_Z: begin
                    mb = tabs_pkg::AXIS_Y;
                    mc = tabs_pkg::AXIS_X;
                end
                default: begin
                    mb = tabs_pkg::AXIS_Y;
                    mc = tabs_pkg::AXIS_Z;
                end
            endcase
            // unfinished repeat runs first, major then minors
            if (st.count[m] != 4'd0) advance_phase(st, m);
            if (st.count[mb] != 4'd0) advance_phase(st, mb);
            if (st.count[mc] != 4'd0) advance_phase(st, mc);
            if (st.count == '0) begin
                if (st.pos[m] != st.tgt[m]) begin
                    st.count[m] = repeat_eff(st, m);
                    advance_phase(st, m);
                end
                minor_advance(st, mb, st.span[m]);
                minor_advance(st, mc, st.span[m]);
                if (axes_home(st)) fin = 1'b1;
            end
        end
        res.coil_x = st.coil[0];
        res.coil_y = st.coil[1];
        res.coil_z = st.coil[2];
        res.position_x = st.pos[0];
        res.position_y = st.pos[1];
        res.position_z = st.pos[2];
        res.finished = fin;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      result_idx, name, got, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // command driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (cmd_fifo.size() != 0) begin
                cmd_on_bus = cmd_fifo.pop_front();
                s_op <= cmd_on_bus.op;
                s_target_x <= cmd_on_bus.target_x;
                s_target_y <= cmd_on_bus.target_y;
                s_target_z <= cmd_on_bus.target_z;
                s_running <= cmd_on_bus.running;
                s_valid <= 1'b1;
                if ($urandom_range(0, 99) < send_idle_pct) send_gap = $urandom_range(1, 14);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < recv_idle_pct) recv_stall = $urandom_range(1, 14);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predict on every accepted command, compare every result
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen_cmd.op = tabs_pkg::op_t'(s_op);
                seen_cmd.target_x = s_target_x;
                seen_cmd.target_y = s_target_y;
                seen_cmd.target_z = s_target_z;
                seen_cmd.running = s_running;
                coil_pos_fifo.push_back(stepper_advance(live, seen_cmd));
                cmds_taken++;
            end
            if (m_valid && m_ready) begin
                if (coil_pos_fifo.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none outstanding",
                                              result_idx));
                end else begin
                    want_res = coil_pos_fifo.pop_front();
                    check_field("coil_x", m_coil_x, want_res.coil_x);
                    check_field("coil_y", m_coil_y, want_res.coil_y);
                    check_field("coil_z", m_coil_z, want_res.coil_z);
                    check_field("position_x", m_position_x, want_res.position_x);
                    check_field("position_y", m_position_y, want_res.position_y);
                    check_field("position_z", m_position_z, want_res.position_z);
                    check_field("finished", m_finished, want_res.finished);
                end
                result_idx++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // apb access and stimulus
    // ------------------------------------------------------------------------
    task automatic apb_write(input tabs_pkg::reg_idx_t r, input logic [3:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= {28'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read_check(input tabs_pkg::reg_idx_t r);
        logic [tabs_pkg::APB_DATA_BITS-1:0] got;
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {r, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== {28'd0, live.repeat_cfg[r]}) begin
            report_mismatch($sformatf("register %s reads %0h, want %0h", r.name(), got,
                                      live.repeat_cfg[r]));
        end
    endtask

    // drain everything sent so far before touching the registers
    task automatic wait_idle();
        while (cmds_taken != cmds_planned || coil_pos_fifo.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic push_cmd(input tabs_pkg::op_t op, input logic [31:0] tx,
                            input logic [31:0] ty, input logic [31:0] tz,
                            input logic run);
        stepper_cmd_t c;
        c.op = op;
        c.target_x = tx;
        c.target_y = ty;
        c.target_z = tz;
        c.running = run;
        void'(stepper_advance(plan, c));
        cmd_fifo.push_back(c);
        cmds_planned++;
    endtask

    task automatic push_tick(input logic run);
        push_cmd(tabs_pkg::OP_TICK, $urandom, $urandom, $urandom, run);
    endtask

    // target relative to where the planned position will be
    task automatic push_load_rel(input int dx, input int dy, input int dz);
        push_cmd(tabs_pkg::OP_LOAD, plan.pos[0] + 32'(dx), plan.pos[1] + 32'(dy),
                 plan.pos[2] + 32'(dz), 1'($urandom_range(0, 1)));
    endtask

    function automatic int rand_offset(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    task automatic fill_random(input int budget);
        int start_cnt;
        int sel;
        int worst;
        int rmax;
        int ticks;
        int cap;
        worst = 1;
        for (int a = 0; a < tabs_pkg::AXES; a++) begin
            if (int'(repeat_eff(plan, tabs_pkg::axis_t'(a))) > worst) begin
                worst = int'(repeat_eff(plan, tabs_pkg::axis_t'(a)));
            end
        end
        // keep moves short when every position step costs many ticks
        rmax = 1 + 36 / worst;
        start_cnt = cmds_planned;
        while (cmds_planned - start_cnt < budget) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                push_load_rel(rand_offset(rmax), rand_offset(rmax), rand_offset(rmax));
                cap = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 4) : 1000;
                ticks = 0;
                while (!axes_home(plan) && ticks < cap) begin
                    push_tick($urandom_range(0, 11) != 0);
                    ticks++;
                end
                if (ticks < cap) repeat ($urandom_range(0, 2)) push_tick(1'b1);
            end else if (sel < 90) begin
                push_cmd(tabs_pkg::OP_LOAD, $urandom, $urandom, $urandom,
                         1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 6)) push_tick(1'b1);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    push_cmd(tabs_pkg::op_t'($urandom_range(0, 1)), $urandom, $urandom,
                             $urandom, 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial begin
        logic [2:0][3:0] new_cfg;
        live = home_state();
        plan = home_state();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        for (int r = 0; r < tabs_pkg::AXES; r++) apb_read_check(tabs_pkg::reg_idx_t'(r));

        send_idle_pct = 20;
        recv_idle_pct = 20;
        push_tick(1'b0);
        push_tick(1'b1);
        push_load_rel(3, -1, 2);
        repeat (4) push_tick(1'b1);
        push_tick(1'b0);
        // y and z tie above x, y wins; move cut short by the next load
        push_load_rel(2, 4, -4);
        repeat (3) push_tick(1'b1);
        push_load_rel(1, -2, 5);
        repeat (2) push_tick(1'b1);
        push_load_rel(2, 2, 2);
        push_tick(1'b1);
        push_cmd(tabs_pkg::OP_LOAD, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b1);
        repeat (2) push_tick(1'b1);
        push_load_rel(0, 0, 0);
        push_tick(1'b1);
        push_cmd(tabs_pkg::OP_LOAD, 32'd0, 32'd0, 32'd0, 1'b0);
        fill_random(150);

        for (int ph = 1; ph <= 6; ph++) begin
            wait_idle();
            case (ph)
                1: new_cfg = {4'd0, 4'd0, 4'd0};
                2: new_cfg = {4'd15, 4'd15, 4'd15};
                3: new_cfg = {4'd1, 4'd0, 4'd15};
                4: new_cfg = {4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15))};
                5: new_cfg = {4'($urandom_range(1, 3)), 4'($urandom_range(1, 3)),
                              4'($urandom_range(1, 3))};
                default: new_cfg = {4'($urandom_range(0, 4)), 4'($urandom_range(0, 4)),
                                    4'($urandom_range(0, 4))};
            endcase
            for (int r = 0; r < tabs_pkg::AXES; r++) begin
                apb_write(tabs_pkg::reg_idx_t'(r), new_cfg[r]);
                live.repeat_cfg[r] = new_cfg[r];
                plan.repeat_cfg[r] = new_cfg[r];
            end
            for (int r = 0; r < tabs_pkg::AXES; r++) begin
                apb_read_check(tabs_pkg::reg_idx_t'(r));
            end
            // full rate on both sides for the closing stretch
            send_idle_pct = (ph == 6) ? 0 : IDLE_PCT[$urandom_range(0, 3)];
            recv_idle_pct = (ph == 6) ? 0 : IDLE_PCT[$urandom_range(0, 3)];
            fill_random((ph == 6) ? 300 : 240);
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (coil_pos_fifo.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", coil_pos_fifo.size()));
        end
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
